>>> rtl/vtdi_pkg.sv
package vtdi_pkg;

  localparam int FIELD_W = 16;
  localparam int OUT_IDX_W = 8;
  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_POS     = 2'd0,
    MODE_POS_NRM = 2'd1,
    MODE_POS_UV  = 2'd2,
    MODE_ALL     = 2'd3
  } attr_mode_t;

  localparam attr_mode_t MODE_RESET = MODE_ALL;

  // Corner under search, broadcast to every cell while a transaction runs.
  typedef struct packed {
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] uv;
    logic [FIELD_W-1:0] nrm;
    logic               use_uv;
    logic               use_nrm;
  } query_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic                 is_new;
    logic [OUT_IDX_W-1:0] hit_idx;
  } token_t;

endpackage

>>> rtl/vtdi_if.sv
interface vtdi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position_index;
  logic [15:0] texcoord_index;
  logic [15:0] normal_index;
  logic        clear_table;

  modport source (
    output valid, position_index, texcoord_index, normal_index, clear_table,
    input  ready
  );
  modport sink (
    input  valid, position_index, texcoord_index, normal_index, clear_table,
    output ready
  );
endinterface

interface vtdi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] output_index;
  logic       is_new;
  logic       overflow;

  modport source (output valid, output_index, is_new, overflow, input ready);
  modport sink   (input valid, output_index, is_new, overflow, output ready);
endinterface

interface vtdi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] attr_mode;

  modport source (output valid, attr_mode, input ready);
  modport sink   (input valid, attr_mode, output ready);
endinterface

>>> rtl/vtdi_cell.sv
module vtdi_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vtdi_pkg::query_t   query,
  input  logic [CNT_W-1:0]   count,
  input  vtdi_pkg::token_t   tok_in,
  output vtdi_pkg::token_t   tok_out
);
  import vtdi_pkg::*;

  localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(CELL_IDX);
  localparam logic [OUT_IDX_W-1:0] MY_HIT = OUT_IDX_W'(CELL_IDX);

  logic [FIELD_W-1:0] pos_r;
  logic [FIELD_W-1:0] uv_r;
  logic [FIELD_W-1:0] nrm_r;
  token_t             tok_r;
  token_t             tok_nxt;
  logic               match;
  logic               searching;
  logic               hit;
  logic               append;

  always_comb begin
    match = (pos_r == query.pos) &&
            (!query.use_uv || (uv_r == query.uv)) &&
            (!query.use_nrm || (nrm_r == query.nrm));
    searching = tok_in.active && !tok_in.found;
    hit = searching && (MY_SLOT < count) && match;
    append = searching && (MY_SLOT == count);
    tok_nxt = tok_in;
    if (hit || append) begin
      tok_nxt.found = 1'b1;
      tok_nxt.is_new = append;
      tok_nxt.hit_idx = MY_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      pos_r <= query.pos;
      uv_r <= query.uv;
      nrm_r <= query.nrm;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/vertex_triple_dedup_indexer_core.sv
// Corner deduplicator for indexed meshes.
// in_ch carries one face corner per transaction: position, texture-coordinate
// and normal indices plus clear_table, which empties the table first.
// out_ch returns one transaction per corner: the index of the first stored
// entry that matches under the current mode, or the newly appended index with
// is_new set, or overflow set with index zero when the table is full.
// cfg_ch writes attr_mode, which selects the compared fields; it is always
// ready and should only be written while no corner is in flight.
// The table is a row of TABLE_DEPTH cells, each holding one entry. A search
// token enters the first cell the cycle after acceptance and moves one cell
// per cycle; the cell at the fill count appends a missed corner.
// A result passes from the end of the row into the holding register and then
// into the output register before it appears on out_ch; in_ch takes no new
// corner until the token of the last one has walked off the end of the row.
// One finished result can wait in the output register while out_ch is
// stalled, so the next corner is accepted behind it; a second waiting result
// holds in_ch not ready until the receiver takes the first.
// Reset empties the table, sets attr_mode to all three fields and drops any
// pending transactions.
module vertex_triple_dedup_indexer_core #(
  parameter int TABLE_DEPTH = 256
) (
  input logic clk,
  input logic rst_n,
  vtdi_in_if.sink    in_ch,
  vtdi_out_if.source out_ch,
  vtdi_cfg_if.sink   cfg_ch
);
  import vtdi_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  attr_mode_t             mode_r;
  attr_mode_t             mode_nxt;
  query_t                 query_r;
  query_t                 query_nxt;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   busy_r;
  logic                   busy_nxt;
  logic                   start_r;
  logic                   start_nxt;
  logic                   pend_valid_r;
  logic                   pend_valid_nxt;
  logic [OUT_IDX_W-1:0]   pend_idx_r;
  logic [OUT_IDX_W-1:0]   pend_idx_nxt;
  logic                   pend_new_r;
  logic                   pend_new_nxt;
  logic                   pend_ovf_r;
  logic                   pend_ovf_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r;
  logic [OUT_IDX_W-1:0]   out_idx_nxt;
  logic                   out_new_r;
  logic                   out_new_nxt;
  logic                   out_ovf_r;
  logic                   out_ovf_nxt;
  logic                   in_fire;
  logic                   out_load;
  token_t                 tok_link [TABLE_DEPTH+1];
  token_t                 chain_out;

  assign in_ch.ready = !busy_r && !pend_valid_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign chain_out = tok_link[TABLE_DEPTH];
  assign out_load = pend_valid_r && (!out_valid_r || out_ch.ready);

  assign tok_link[0] = '{active: start_r, found: 1'b0, is_new: 1'b0, hit_idx: '0};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    vtdi_cell #(
      .CELL_IDX(g),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .query  (query_r),
      .count  (count_r),
      .tok_in (tok_link[g]),
      .tok_out(tok_link[g+1])
    );
  end

  always_comb begin
    mode_nxt = mode_r;
    query_nxt = query_r;
    count_nxt = count_r;
    busy_nxt = busy_r;
    start_nxt = 1'b0;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt = pend_idx_r;
    pend_new_nxt = pend_new_r;
    pend_ovf_nxt = pend_ovf_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt = out_idx_r;
    out_new_nxt = out_new_r;
    out_ovf_nxt = out_ovf_r;

    if (cfg_ch.valid) begin
      mode_nxt = attr_mode_t'(cfg_ch.attr_mode);
    end

    if (in_fire) begin
      query_nxt.pos = in_ch.position_index;
      query_nxt.uv = in_ch.texcoord_index;
      query_nxt.nrm = in_ch.normal_index;
      query_nxt.use_uv = (mode_r == MODE_POS_UV) || (mode_r == MODE_ALL);
      query_nxt.use_nrm = (mode_r == MODE_POS_NRM) || (mode_r == MODE_ALL);
      if (in_ch.clear_table) begin
        count_nxt = '0;
      end
      busy_nxt = 1'b1;
      start_nxt = 1'b1;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt = pend_idx_r;
      out_new_nxt = pend_new_r;
      out_ovf_nxt = pend_ovf_r;
      pend_valid_nxt = 1'b0;
    end

    if (chain_out.active) begin
      busy_nxt = 1'b0;
      pend_valid_nxt = 1'b1;
      pend_idx_nxt = chain_out.found ? chain_out.hit_idx : '0;
      pend_new_nxt = chain_out.is_new;
      pend_ovf_nxt = !chain_out.found;
      if (chain_out.is_new) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      count_r <= '0;
      busy_r <= 1'b0;
      start_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      count_r <= count_nxt;
      busy_r <= busy_nxt;
      start_r <= start_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_new_r <= pend_new_nxt;
    pend_ovf_r <= pend_ovf_nxt;
    out_idx_r <= out_idx_nxt;
    out_new_r <= out_new_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.output_index = out_idx_r;
  assign out_ch.is_new = out_new_r;
  assign out_ch.overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_token_only_when_busy: assert property (
    @(posedge clk) disable iff (!rst_n) chain_out.active |-> busy_r
  ) else $error("search token left the row with no transaction in flight");

  a_count_in_range: assert property (
    @(posedge clk) disable iff (!rst_n) count_r <= DEPTH_CNT
  ) else $error("fill count exceeds table depth");

  a_new_excludes_overflow: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> !(out_new_r && out_ovf_r)
  ) else $error("result flags both new and overflow");

  a_pend_from_search: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(pend_valid_r) |-> $past(busy_r)
  ) else $error("held result appeared without a search");

  a_overflow_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
      (chain_out.active && !chain_out.found) |-> (count_r == DEPTH_CNT)
  ) else $error("miss reported while a free slot remained");
`endif

endmodule
